FILE: hw/rtl/rgbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbw_pkg: shared types, constants and table function
// Register map, controller state and command types, and the sine entry
// generator used to fill the breathing table.
// ----------------------------------------------------------------------------
package rgbw_pkg;

  localparam int PHASE_BITS_DEF   = 16;
  localparam int SINE_ENTRIES_DEF = 256;
  localparam int DUTY_BITS_DEF    = 13;

  localparam int TARGET_W      = 8;
  localparam int TARGET_LEVELS = 256;
  localparam int TARGET_MAX    = 255;
  localparam int FACTOR_W      = 16;
  localparam int NUM_CH        = 4;
  localparam int CH_W          = 2;

  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int PHASE_INC_W   = 16;
  localparam int PHASE_INC_RST = 522;

  localparam logic [CFG_INDEX_W-1:0] REG_RED_TARGET   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_TARGET = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_TARGET  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WHITE_TARGET = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BREATH_EN    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC    = 3'd5;

  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
  localparam logic [CH_W-1:0] CH_WHITE = 2'd3;
  localparam logic [CH_W-1:0] CH_LAST  = CH_WHITE;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] FACTOR_MAX  = 64'd65535;
  localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROM,
    ST_SQUARE,
    ST_SCALE,
    ST_MAP,
    ST_LOAD
  } rgbw_state_t;

  typedef struct packed {
    logic            accept;
    logic            rom_rd;
    logic            square;
    logic            scale;
    logic            map;
    logic            load_out;
    logic [CH_W-1:0] ch;
  } rgbw_cmd_t;

  typedef struct packed {
    logic out_free;
  } rgbw_status_t;

  // (sin + 1) / 2 in Q0.16 for an angle given as a Q32 fraction of a turn
  function automatic logic [FACTOR_W-1:0] sine_entry(input logic [63:0] angle);
    logic [1:0]  quad;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] f;
    quad = angle[31:30];
    u    = {34'd0, angle[29:0]};
    if (quad[0]) begin
      u = Q30_ONE - u;
    end
    x  = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    h  = Q30_ONE;
    for (int i = 0; i < 5; i++) begin
      d = ((x2 * h) >> 30) / TAYLOR_DIV[i];
      h = (d < Q30_ONE) ? Q30_ONE - d : 64'd0;
    end
    s = (x * h) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    f = quad[1] ? ((Q30_ONE - s) >> 1) : ((Q30_ONE + s) >> 1);
    f = (f * FACTOR_MAX + (Q30_ONE >> 1)) >> 30;
    if (f > FACTOR_MAX) begin
      f = FACTOR_MAX;
    end
    return f[FACTOR_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rgbw_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbw interfaces: tick, duty and configuration channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface rgbw_tick_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface rgbw_duty_if #(
  parameter int DUTY_BITS = rgbw_pkg::DUTY_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] red_duty;
  logic [DUTY_BITS-1:0] green_duty;
  logic [DUTY_BITS-1:0] blue_duty;
  logic [DUTY_BITS-1:0] white_duty;
  modport source (output valid, output red_duty, output green_duty,
                  output blue_duty, output white_duty, input ready);
  modport sink (input valid, input red_duty, input green_duty,
                input blue_duty, input white_duty, output ready);
endinterface

interface rgbw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rgbw_pkg::CFG_INDEX_W-1:0] index;
  logic [rgbw_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rgbw_breathing_pwm_duty.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbw_breathing_pwm_duty: four-channel breathing PWM duty generator
// A tick transfer starts table read, square, per-channel scale and duty map,
// which walk one shared multiplier and duty table over the four channels in
// turn, then a load into the output register; no new tick is taken before
// that load. A waiting result sits in the output register until its transfer.
// Reset: targets and enable clear, phase clears, increment returns to 522.
// ----------------------------------------------------------------------------
module rgbw_breathing_pwm_duty #(
  parameter int PHASE_BITS         = rgbw_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_ENTRIES = rgbw_pkg::SINE_ENTRIES_DEF,
  parameter int DUTY_BITS          = rgbw_pkg::DUTY_BITS_DEF
) (
  input wire           clk,
  input wire           rst,
  rgbw_tick_if.sink    tick_ch,
  rgbw_duty_if.source  duty_ch,
  rgbw_cfg_if.sink     cfg
);

  rgbw_pkg::rgbw_cmd_t    cmd;
  rgbw_pkg::rgbw_status_t status;
  logic                   in_ready;
  logic                   out_valid;
  logic [DUTY_BITS-1:0]   red_duty;
  logic [DUTY_BITS-1:0]   green_duty;
  logic [DUTY_BITS-1:0]   blue_duty;
  logic [DUTY_BITS-1:0]   white_duty;

  assign cfg.ready          = 1'b1;
  assign tick_ch.ready      = in_ready;
  assign duty_ch.valid      = out_valid;
  assign duty_ch.red_duty   = red_duty;
  assign duty_ch.green_duty = green_duty;
  assign duty_ch.blue_duty  = blue_duty;
  assign duty_ch.white_duty = white_duty;

  rgbw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rgbw_dp #(
    .PHASE_BITS         (PHASE_BITS),
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .DUTY_BITS          (DUTY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .tick       (tick_ch.tick),
    .cfg_wr     (cfg.valid && cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (out_valid),
    .out_ready  (duty_ch.ready),
    .red_duty   (red_duty),
    .green_duty (green_duty),
    .blue_duty  (blue_duty),
    .white_duty (white_duty)
  );

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (tick_ch.valid && tick_ch.ready) |=> !tick_ch.ready)
    else $error("tick accepted while an item is in flight");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("output register overwritten before its transfer");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(duty_ch.valid) |-> $past(cmd.load_out))
    else $error("duty result raised without a load");

endmodule
`default_nettype wire

FILE: hw/rtl/rgbw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbw_ctrl: sequencing controller
// Steps one item through table read, square, per-channel scale, duty map and output load.
// ----------------------------------------------------------------------------
module rgbw_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  rgbw_pkg::rgbw_status_t status,
  output rgbw_pkg::rgbw_cmd_t    cmd
);

  rgbw_pkg::rgbw_state_t     state;
  rgbw_pkg::rgbw_state_t     state_next;
  logic [rgbw_pkg::CH_W-1:0] ch;
  logic [rgbw_pkg::CH_W-1:0] ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgbw_pkg::ST_IDLE;
      ch    <= rgbw_pkg::CH_RED;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    case (state)
      rgbw_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = rgbw_pkg::ST_ROM;
        end
      end
      rgbw_pkg::ST_ROM:    state_next = rgbw_pkg::ST_SQUARE;
      rgbw_pkg::ST_SQUARE: state_next = rgbw_pkg::ST_SCALE;
      rgbw_pkg::ST_SCALE: begin
        ch_next = ch + 1'b1;
        if (ch == rgbw_pkg::CH_LAST) begin
          state_next = rgbw_pkg::ST_MAP;
        end
      end
      rgbw_pkg::ST_MAP: begin
        ch_next = ch + 1'b1;
        if (ch == rgbw_pkg::CH_LAST) begin
          state_next = rgbw_pkg::ST_LOAD;
        end
      end
      rgbw_pkg::ST_LOAD: begin
        if (status.out_free) begin
          state_next = rgbw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rgbw_pkg::ST_IDLE;
        ch_next    = rgbw_pkg::CH_RED;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.ch       = ch;
    case (state)
      rgbw_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      rgbw_pkg::ST_ROM:    cmd.rom_rd   = 1'b1;
      rgbw_pkg::ST_SQUARE: cmd.square   = 1'b1;
      rgbw_pkg::ST_SCALE:  cmd.scale    = 1'b1;
      rgbw_pkg::ST_MAP:    cmd.map      = 1'b1;
      rgbw_pkg::ST_LOAD:   cmd.load_out = status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rgbw_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbw_dp: breathing datapath
// Configuration registers, phase accumulator, sine table, shared multiplier,
// duty map table and output register.
// ----------------------------------------------------------------------------
module rgbw_dp #(
  parameter int PHASE_BITS         = rgbw_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_ENTRIES = rgbw_pkg::SINE_ENTRIES_DEF,
  parameter int DUTY_BITS          = rgbw_pkg::DUTY_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  rgbw_pkg::rgbw_cmd_t                   cmd,
  output rgbw_pkg::rgbw_status_t                status,
  input  wire                                   tick,
  input  wire                                   cfg_wr,
  input  wire [rgbw_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire [rgbw_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [DUTY_BITS-1:0]                  red_duty,
  output logic [DUTY_BITS-1:0]                  green_duty,
  output logic [DUTY_BITS-1:0]                  blue_duty,
  output logic [DUTY_BITS-1:0]                  white_duty
);

  localparam int IDX_W    = $clog2(SINE_TABLE_ENTRIES);
  localparam int PROD_W   = PHASE_BITS + IDX_W + 1;
  localparam int DUTY_MAX = (1 << DUTY_BITS) - 1;
  localparam int TW       = rgbw_pkg::TARGET_W;
  localparam int FW       = rgbw_pkg::FACTOR_W;

  logic [TW-1:0]         target [rgbw_pkg::NUM_CH];
  logic                  breath_en;
  logic [PHASE_BITS-1:0] phase_inc;
  logic [PHASE_BITS-1:0] phase;
  logic [FW-1:0]         factor;
  logic [FW-1:0]         factor_sq;
  logic [TW-1:0]         level [rgbw_pkg::NUM_CH];
  logic [DUTY_BITS-1:0]  duty [rgbw_pkg::NUM_CH];

  logic [FW-1:0]         sine_tab [SINE_TABLE_ENTRIES];
  logic [DUTY_BITS-1:0]  duty_tab [rgbw_pkg::TARGET_LEVELS];
  logic [PROD_W-1:0]     idx_prod;
  logic [IDX_W-1:0]      idx;
  logic [2*FW-1:0]       sq_prod;
  logic [TW+FW-1:0]      scale_prod;

  for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_sine
    localparam logic [63:0] ANGLE = (64'(k) << 32) / SINE_TABLE_ENTRIES;
    assign sine_tab[k] = rgbw_pkg::sine_entry(ANGLE);
  end

  for (genvar k = 0; k < rgbw_pkg::TARGET_LEVELS; k++) begin : g_duty
    localparam int DUTY_K = (k * DUTY_MAX) / rgbw_pkg::TARGET_MAX;
    assign duty_tab[k] = DUTY_BITS'(DUTY_K);
  end

  assign idx_prod   = PROD_W'(phase) * PROD_W'(SINE_TABLE_ENTRIES);
  assign idx        = idx_prod[PHASE_BITS +: IDX_W];
  assign sq_prod    = factor * factor;
  assign scale_prod = target[cmd.ch] * factor_sq;

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rgbw_pkg::NUM_CH; i++) begin
        target[i] <= '0;
      end
      breath_en <= 1'b0;
      phase_inc <= PHASE_BITS'(rgbw_pkg::PHASE_INC_RST);
      phase     <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          rgbw_pkg::REG_RED_TARGET:   target[rgbw_pkg::CH_RED]   <= cfg_data[TW-1:0];
          rgbw_pkg::REG_GREEN_TARGET: target[rgbw_pkg::CH_GREEN] <= cfg_data[TW-1:0];
          rgbw_pkg::REG_BLUE_TARGET:  target[rgbw_pkg::CH_BLUE]  <= cfg_data[TW-1:0];
          rgbw_pkg::REG_WHITE_TARGET: target[rgbw_pkg::CH_WHITE] <= cfg_data[TW-1:0];
          rgbw_pkg::REG_BREATH_EN:    breath_en <= cfg_data[0];
          rgbw_pkg::REG_PHASE_INC:
            phase_inc <= PHASE_BITS'(cfg_data[rgbw_pkg::PHASE_INC_W-1:0]);
          default: begin
          end
        endcase
      end
      if (cmd.accept && tick && breath_en) begin
        phase <= phase + phase_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rom_rd) begin
      factor <= sine_tab[idx];
    end
    if (cmd.square) begin
      factor_sq <= sq_prod[2*FW-1:FW];
    end
    if (cmd.scale) begin
      level[cmd.ch] <= breath_en ? scale_prod[TW+FW-1:FW] : target[cmd.ch];
    end
    if (cmd.map) begin
      duty[cmd.ch] <= duty_tab[level[cmd.ch]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_duty   <= duty[rgbw_pkg::CH_RED];
      green_duty <= duty[rgbw_pkg::CH_GREEN];
      blue_duty  <= duty[rgbw_pkg::CH_BLUE];
      white_duty <= duty[rgbw_pkg::CH_WHITE];
    end
  end

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: rgbw_breathing_pwm_duty
// Writes targets, breathing enable and phase step between bursts of ticks,
// with random gaps on both channels and one long hold-off on the duty side.
// A local breathing model or a plan row predicts each duty set, and every
// duty transfer is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import rgbw_pkg::*;

  localparam int          RANDOM_TICKS     = 1350;
  localparam int          HOLD_OFF_CYCLES  = 300;
  localparam int          DRAIN_CYCLES     = 30;
  localparam int          ROM_SIZE         = 256;
  localparam int          PLAN_ROWS        = 38;
  localparam logic [12:0] DUTY_FULL        = 13'd8191;
  localparam logic [63:0] ONE_Q30          = 64'd1 << 30;
  localparam logic [63:0] QUARTER_TURN_RAD = 64'd1686629713;
  localparam logic [63:0] HORNER_DIV [5]   = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [12:0] red;
    logic [12:0] green;
    logic [12:0] blue;
    logic [12:0] white;
  } duty_set_t;

  typedef struct packed {
    logic      known;
    duty_set_t want;
  } preset_t;

  typedef enum logic { ROW_WRITE, ROW_TICK } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    logic                   tick;
    logic                   known;
    duty_set_t              want;
  } row_t;

  localparam duty_set_t DUTY_DARK   = '0;
  localparam duty_set_t DUTY_BRIGHT = '{DUTY_FULL, DUTY_FULL, DUTY_FULL, DUTY_FULL};
  localparam duty_set_t DUTY_MIXED  = '{DUTY_FULL, 13'd0, 13'd4111, 13'd32};

  localparam row_t PLAN [PLAN_ROWS] = '{
    '{ROW_TICK,  '0,               '0,        1'b0, 1'b1, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b1, DUTY_DARK},
    '{ROW_WRITE, REG_RED_TARGET,   16'd255,   1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_GREEN_TARGET, 16'd0,     1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_BLUE_TARGET,  16'd128,   1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_WHITE_TARGET, 16'd1,     1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b1, DUTY_MIXED},
    '{ROW_WRITE, REG_RED_TARGET,   16'hAB12,  1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_SPARE_LO,     16'hFFFF,  1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_SPARE_HI,     16'h5A5A,  1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_PHASE_INC,    16'd0,     1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_BREATH_EN,    16'hFFFE,  1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_BREATH_EN,    16'h0001,  1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_PHASE_INC,    16'd16384, 1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b1, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_PHASE_INC,    16'hFFFF,  1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_BREATH_EN,    16'd0,     1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_RED_TARGET,   16'd255,   1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_GREEN_TARGET, 16'd255,   1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_BLUE_TARGET,  16'd255,   1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_WHITE_TARGET, 16'hFFFF,  1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b0, 1'b1, DUTY_BRIGHT},
    '{ROW_WRITE, REG_BREATH_EN,    16'd1,     1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_RED_TARGET,   16'd0,     1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_GREEN_TARGET, 16'd0,     1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_BLUE_TARGET,  16'd0,     1'b0, 1'b0, DUTY_DARK},
    '{ROW_WRITE, REG_WHITE_TARGET, 16'hFF00,  1'b0, 1'b0, DUTY_DARK},
    '{ROW_TICK,  '0,               '0,        1'b1, 1'b1, DUTY_DARK}
  };

  logic clk;
  logic rst;

  rgbw_tick_if tick_bus ();
  rgbw_duty_if duty_bus ();
  rgbw_cfg_if  cfg_bus ();

  rgbw_breathing_pwm_duty dut (
    .clk     (clk),
    .rst     (rst),
    .tick_ch (tick_bus),
    .duty_ch (duty_bus),
    .cfg     (cfg_bus)
  );

  logic [7:0]  level_reg [NUM_CH];
  logic        breathing_on;
  logic [15:0] phase_step;
  logic [15:0] breath_angle;
  logic [15:0] sine_rom [ROM_SIZE];

  duty_set_t pending_duties [$];
  preset_t   preset_duties [$];

  int ticks_sent;
  int duty_sets_seen;
  int errors;
  int tx_calm;
  int rx_calm;
  bit hold_off_armed;

  // (sin + 1) / 2 in Q0.16 for table entry k
  function automatic logic [15:0] sine_level(input int unsigned k);
    logic [63:0] turn;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] f;
    turn = (64'(k) << 32) / 64'(ROM_SIZE);
    u    = {34'd0, turn[29:0]};
    if (turn[30]) begin
      u = ONE_Q30 - u;
    end
    x  = (u * QUARTER_TURN_RAD) >> 30;
    x2 = (x * x) >> 30;
    h  = ONE_Q30;
    for (int i = 0; i < 5; i++) begin
      d = ((x2 * h) >> 30) / HORNER_DIV[i];
      h = (d < ONE_Q30) ? ONE_Q30 - d : 64'd0;
    end
    s = (x * h) >> 30;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    f = turn[31] ? (ONE_Q30 - s) >> 1 : (ONE_Q30 + s) >> 1;
    f = (f * 64'd65535 + (ONE_Q30 >> 1)) >> 30;
    if (f > 64'd65535) begin
      f = 64'd65535;
    end
    return f[15:0];
  endfunction

  function automatic logic [12:0] duty_of(input logic [7:0] v);
    return 13'((32'(v) * 32'(DUTY_FULL)) / 32'd255);
  endfunction

  // when breathing, advance the phase if asked and scale the levels; then map the four levels to duties
  function automatic duty_set_t breathe_step(input logic advance);
    logic [15:0] entry;
    logic [31:0] gain;
    logic [7:0]  lvl [NUM_CH];
    duty_set_t   ds;
    for (int c = 0; c < NUM_CH; c++) begin
      lvl[c] = level_reg[c];
    end
    if (breathing_on) begin
      if (advance) begin
        breath_angle = breath_angle + phase_step;
      end
      entry = sine_rom[breath_angle[15:8]];
      gain  = (32'(entry) * 32'(entry)) >> 16;
      for (int c = 0; c < NUM_CH; c++) begin
        lvl[c] = 8'((32'(level_reg[c]) * gain) >> 16);
      end
    end
    ds.red   = duty_of(lvl[CH_RED]);
    ds.green = duty_of(lvl[CH_GREEN]);
    ds.blue  = duty_of(lvl[CH_BLUE]);
    ds.white = duty_of(lvl[CH_WHITE]);
    return ds;
  endfunction

  function automatic void check_field(input string name, input logic [12:0] want,
                                      input logic [12:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic int tx_gap();
    int r;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      tx_calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(12, 40);
  endfunction

  function automatic int rx_stall();
    int r;
    if (rx_calm > 0) begin
      rx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      rx_calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_tick(input logic advance);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      tick_bus.valid <= 1'b0;
      tick_bus.tick  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.tick  <= advance;
    do @(posedge clk); while (!tick_bus.ready);
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_INDEX_W'($urandom);
    cfg_bus.data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
  endtask

  // drop the tick valid and wait until every duty set is back
  task automatic settle();
    tick_bus.valid <= 1'b0;
    while (duty_sets_seen != ticks_sent) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin : duty_monitor
    preset_t   preset;
    duty_set_t guess;
    duty_set_t want;
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_RED_TARGET:   level_reg[CH_RED]   = cfg_bus.data[7:0];
          REG_GREEN_TARGET: level_reg[CH_GREEN] = cfg_bus.data[7:0];
          REG_BLUE_TARGET:  level_reg[CH_BLUE]  = cfg_bus.data[7:0];
          REG_WHITE_TARGET: level_reg[CH_WHITE] = cfg_bus.data[7:0];
          REG_BREATH_EN:    breathing_on        = cfg_bus.data[0];
          REG_PHASE_INC:    phase_step          = cfg_bus.data[15:0];
          default: ;
        endcase
      end
      if (tick_bus.valid && tick_bus.ready) begin
        guess = breathe_step(tick_bus.tick);
        if (preset_duties.size() > 0) begin
          preset = preset_duties.pop_front();
          if (preset.known) begin
            guess = preset.want;
          end
        end
        pending_duties.push_back(guess);
      end
      if (duty_bus.valid && duty_bus.ready) begin
        duty_sets_seen++;
        if (pending_duties.size() == 0) begin
          errors++;
          $display("%0t: duty transfer with none expected: %0d %0d %0d %0d", $time,
                   duty_bus.red_duty, duty_bus.green_duty, duty_bus.blue_duty,
                   duty_bus.white_duty);
        end else begin
          want = pending_duties.pop_front();
          check_field("red_duty", want.red, duty_bus.red_duty);
          check_field("green_duty", want.green, duty_bus.green_duty);
          check_field("blue_duty", want.blue, duty_bus.blue_duty);
          check_field("white_duty", want.white, duty_bus.white_duty);
        end
      end
    end
  end

  initial begin : duty_sink
    int stall;
    duty_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        duty_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = rx_stall();
        if (stall > 0) begin
          duty_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        duty_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int                     ph;
    int                     burst;
    int                     sent_random;
    int                     pick;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  val;
    rst            <= 1'b1;
    tick_bus.valid <= 1'b0;
    tick_bus.tick  <= 1'b0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= '0;
    cfg_bus.data   <= '0;
    ticks_sent     = 0;
    duty_sets_seen = 0;
    errors         = 0;
    tx_calm        = 0;
    rx_calm        = 0;
    hold_off_armed = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      level_reg[c] = 8'd0;
    end
    breathing_on = 1'b0;
    phase_step   = 16'(PHASE_INC_RST);
    breath_angle = 16'd0;
    for (int k = 0; k < ROM_SIZE; k++) begin
      sine_rom[k] = sine_level(k);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        settle();
        write_reg(PLAN[r].index, PLAN[r].data);
      end else begin
        preset_duties.push_back(preset_t'{PLAN[r].known, PLAN[r].want});
        send_tick(PLAN[r].tick);
      end
    end

    sent_random = 0;
    ph          = 0;
    while (sent_random < RANDOM_TICKS) begin
      settle();
      for (int i = 0; i < 6; i++) begin
        reg_idx = CFG_INDEX_W'(i);
        if (ph == 0 || $urandom_range(0, 9) < 6) begin
          val  = CFG_DATA_W'($urandom);
          pick = $urandom_range(0, 6);
          case (reg_idx)
            REG_BREATH_EN: val[0] = ($urandom_range(0, 4) != 0);
            REG_PHASE_INC: begin
              case (pick)
                0: val = 16'd0;
                1: val = 16'd1;
                2: val = 16'hFFFF;
                3: val = 16'(PHASE_INC_RST);
                4: ;
                default: val = 16'($urandom_range(1, 3000));
              endcase
            end
            default: begin
              if (pick == 0) val[7:0] = 8'h00;
              if (pick == 1) val[7:0] = 8'hFF;
            end
          endcase
          write_reg(reg_idx, val);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  CFG_DATA_W'($urandom));
      end
      if (ph == 2) begin
        hold_off_armed = 1'b1;
      end
      burst = $urandom_range(50, 130);
      if (burst > RANDOM_TICKS - sent_random) begin
        burst = RANDOM_TICKS - sent_random;
      end
      repeat (burst) begin
        preset_duties.push_back(preset_t'{1'b0, DUTY_DARK});
        send_tick($urandom_range(0, 3) != 0);
        sent_random++;
      end
      ph++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_duties.size() != 0) begin
      errors++;
      $display("%0t: %0d duty sets never arrived", $time, pending_duties.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rgbw_pkg.sv
hw/rtl/rgbw_ifs.sv
hw/rtl/rgbw_ctrl.sv
hw/rtl/rgbw_dp.sv
hw/rtl/rgbw_breathing_pwm_duty.sv
test/testbench.sv
